// ===== rtl/qet_pkg.sv =====
`timescale 1ns / 1ps

package qet_pkg;

	localparam int SET_CHARS = 8;
	localparam int CFG_W     = 64;
	localparam int ADDR_W    = 5;
	localparam int QDEPTH    = 4;
	localparam int QAW       = $clog2(QDEPTH);

	typedef enum logic [1:0] {
		REG_DELIM  = 2'd0,
		REG_QUOTE  = 2'd1,
		REG_ESCAPE = 2'd2
	} reg_idx_t;

	typedef enum logic {
		RES_BYTE = 1'b0,
		RES_END  = 1'b1
	} res_kind_t;

	typedef struct packed {
		logic [CFG_W-1:0] delim;
		logic [CFG_W-1:0] quote;
		logic [CFG_W-1:0] escape;
	} cfg_t;

	typedef struct packed {
		res_kind_t  kind;
		logic [7:0] data;
	} res_t;

	// one queue entry: the results caused by one input item
	typedef struct packed {
		logic two;
		res_t r0;
		res_t r1;
	} op_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	function automatic logic in_set(input logic [7:0] b, input logic [CFG_W-1:0] set);
		logic hit;
		hit = 1'b0;
		for (int i = 0; i < SET_CHARS; i++) begin
			if (set[8*i +: 8] != 8'd0 && set[8*i +: 8] == b) begin
				hit = 1'b1;
			end
		end
		return hit;
	endfunction

endpackage

// ===== rtl/qet_regs.sv =====
`timescale 1ns / 1ps

module qet_regs
	import qet_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [CFG_W-1:0]  pwdata,
	output logic [CFG_W-1:0]  prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr;

	assign idx    = reg_idx_t'(paddr[ADDR_W-1:3]);
	assign wr     = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr) begin
			case (idx)
				REG_DELIM:  cfg_q.delim  <= pwdata;
				REG_QUOTE:  cfg_q.quote  <= pwdata;
				REG_ESCAPE: cfg_q.escape <= pwdata;
				default:    cfg_q        <= cfg_q;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_DELIM:  prdata = cfg_q.delim;
			REG_QUOTE:  prdata = cfg_q.quote;
			REG_ESCAPE: prdata = cfg_q.escape;
			default:    prdata = '0;
		endcase
	end

endmodule

// ===== rtl/qet_front.sv =====
`timescale 1ns / 1ps

module qet_front
	import qet_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] in_byte,
	input  logic       kind,
	input  qstat_t     qstat,
	output logic       push,
	output op_t        op
);

	logic       esc_pend_q, esc_pend_d;
	logic [7:0] open_quote_q, open_quote_d;
	logic       tok_open_q, tok_open_d;
	logic [7:0] held_q, held_d;
	logic       held_v_q, held_v_d;
	logic       has_res;
	logic       acc;

	assign s_tready = ~qstat.full;
	assign acc      = s_tvalid & s_tready;
	assign push     = acc & has_res;

	always_comb begin
		esc_pend_d   = esc_pend_q;
		open_quote_d = open_quote_q;
		tok_open_d   = tok_open_q;
		held_d       = held_q;
		held_v_d     = held_v_q;
		has_res      = 1'b0;
		op.two       = 1'b0;
		op.r0        = '{kind: RES_BYTE, data: in_byte};
		op.r1        = '{kind: RES_BYTE, data: in_byte};

		if (kind) begin
			// end of string: flush held escape, close token, clear
			if (held_v_q) begin
				has_res = 1'b1;
				op.two  = 1'b1;
				op.r0   = '{kind: RES_BYTE, data: held_q};
				op.r1   = '{kind: RES_END, data: 8'd0};
			end else if (tok_open_q) begin
				has_res = 1'b1;
				op.r0   = '{kind: RES_END, data: 8'd0};
			end
			esc_pend_d   = 1'b0;
			open_quote_d = 8'd0;
			tok_open_d   = 1'b0;
			held_d       = 8'd0;
			held_v_d     = 1'b0;
		end else if (esc_pend_q) begin
			esc_pend_d = 1'b0;
			has_res    = 1'b1;
			tok_open_d = 1'b1;
		end else if (held_v_q) begin
			held_v_d   = 1'b0;
			held_d     = 8'd0;
			has_res    = 1'b1;
			tok_open_d = 1'b1;
			if (!(in_byte == open_quote_q || in_set(in_byte, cfg.escape))) begin
				op.two = 1'b1;
				op.r0  = '{kind: RES_BYTE, data: held_q};
			end
		end else if (open_quote_q != 8'd0) begin
			if (in_byte == open_quote_q) begin
				open_quote_d = 8'd0;
			end else if (in_set(in_byte, cfg.escape)) begin
				held_d   = in_byte;
				held_v_d = 1'b1;
			end else begin
				has_res    = 1'b1;
				tok_open_d = 1'b1;
			end
		end else begin
			if (in_set(in_byte, cfg.delim)) begin
				if (tok_open_q) begin
					has_res    = 1'b1;
					op.r0      = '{kind: RES_END, data: 8'd0};
					tok_open_d = 1'b0;
				end
			end else if (in_set(in_byte, cfg.escape)) begin
				esc_pend_d = 1'b1;
			end else if (in_set(in_byte, cfg.quote)) begin
				tok_open_d   = 1'b1;
				open_quote_d = in_byte;
			end else begin
				has_res    = 1'b1;
				tok_open_d = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_pend_q   <= 1'b0;
			open_quote_q <= 8'd0;
			tok_open_q   <= 1'b0;
			held_q       <= 8'd0;
			held_v_q     <= 1'b0;
		end else if (acc) begin
			esc_pend_q   <= esc_pend_d;
			open_quote_q <= open_quote_d;
			tok_open_q   <= tok_open_d;
			held_q       <= held_d;
			held_v_q     <= held_v_d;
		end
	end

endmodule

// ===== rtl/qet_fifo.sv =====
`timescale 1ns / 1ps

module qet_fifo
	import qet_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  op_t    push_op,
	input  logic   pop,
	output op_t    head,
	output qstat_t qstat
);

	op_t            mem_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   cnt_q;

	assign qstat.full  = (cnt_q == (QAW+1)'(QDEPTH));
	assign qstat.empty = (cnt_q == '0);
	assign head        = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== rtl/qet_back.sv =====
`timescale 1ns / 1ps

module qet_back
	import qet_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  op_t        head,
	input  qstat_t     qstat,
	output logic       pop,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] out_byte,
	output logic       out_kind,
	output logic       last_of_run
);

	logic valid_q;
	res_t res_q;
	logic last_q;
	logic sel_q;
	logic load;
	logic last_d;

	assign load   = ~qstat.empty & (~valid_q | m_tready);
	assign last_d = ~head.two | sel_q;
	assign pop    = load & last_d;

	assign m_tvalid    = valid_q;
	assign out_byte    = res_q.data;
	assign out_kind    = res_q.kind;
	assign last_of_run = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sel_q   <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
			sel_q   <= ~last_d;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q  <= sel_q ? head.r1 : head.r0;
			last_q <= last_d;
		end
	end

endmodule

// ===== rtl/quoted_escaped_tokenizer.sv =====
`timescale 1ns / 1ps

// channel   dir  handshake          tdata              tuser      tlast
// s_        in   s_tvalid/s_tready  [7:0] in_byte      [0] kind   -
// m_        out  m_tvalid/m_tready  [7:0] out_byte     [0] out_kind last_of_run
// apb       in   psel/penable/pready  regs at 0x00 delim, 0x08 quote, 0x10 escape
//
// one input item per cycle while the queue is not full; results leave one per cycle
// while m_tready is high, so an item with two results takes two output transfers
// the front updates token state in the cycle of the transfer, a four-entry queue
// decouples it from the output register
// s_tready drops only when the queue is full; control state clears on arst_n, queue and payload data do not

module quoted_escaped_tokenizer
	import qet_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,  // [7:0] in_byte
	input  logic [0:0]        s_tuser,  // [0] kind
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [7:0]        m_tdata,  // [7:0] out_byte
	output logic [0:0]        m_tuser,  // [0] out_kind
	output logic              m_tlast,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [CFG_W-1:0]  pwdata,
	output logic [CFG_W-1:0]  prdata,
	output logic              pready
);

	cfg_t   cfg;
	qstat_t qstat;
	logic   push;
	logic   pop;
	op_t    push_op;
	op_t    head;
	logic   out_kind;

	assign m_tuser = out_kind;

	qet_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	qet_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.in_byte  (s_tdata),
		.kind     (s_tuser[0]),
		.qstat    (qstat),
		.push     (push),
		.op       (push_op)
	);

	qet_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.pop     (pop),
		.head    (head),
		.qstat   (qstat)
	);

	qet_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.qstat       (qstat),
		.pop         (pop),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.out_byte    (m_tdata),
		.out_kind    (out_kind),
		.last_of_run (m_tlast)
	);

endmodule

// ===== rtl/qet_checker.sv =====
`timescale 1ns / 1ps

module qet_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic [0:0] m_tuser,
	input logic       m_tlast
);

	// stalled output stays up
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output transfer dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
		else $error("output payload changed while stalled");

	// a token end mark carries no byte
	a_end_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata == 8'd0)
		else $error("token end with nonzero byte");

	// a token end mark is always the final result of its item
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tlast)
		else $error("token end not last of run");

endmodule

bind quoted_escaped_tokenizer qet_checker u_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

// ===== sim/qet_token_checker.sv =====
`timescale 1ns / 1ps

module qet_token_checker
	import qet_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	input  logic              s_tready,
	input  logic [7:0]        s_tdata,
	input  logic [0:0]        s_tuser,
	input  logic              m_tvalid,
	input  logic              m_tready,
	input  logic [7:0]        m_tdata,
	input  logic [0:0]        m_tuser,
	input  logic              m_tlast,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [CFG_W-1:0]  pwdata,
	input  logic              pready,
	output int                mismatch_count,
	output int                tokens_pending
);

	typedef struct packed {
		res_kind_t  kind;
		logic [7:0] data;
		logic       last;
	} token_res_t;

	logic [CFG_W-1:0] delim_set;
	logic [CFG_W-1:0] quote_set;
	logic [CFG_W-1:0] esc_set;

	logic       escape_pending;
	logic [7:0] open_quote;
	logic       token_open;
	logic [7:0] held_byte;
	logic       held_valid;

	token_res_t step_res [2];
	int         step_n;
	token_res_t expected_tokens [$];
	token_res_t want;

	function automatic logic in_char_set(input logic [7:0] b, input logic [CFG_W-1:0] chars);
		logic hit;
		hit = 1'b0;
		for (int i = 0; i < SET_CHARS; i++) begin
			if (chars[8*i +: 8] != 8'd0 && chars[8*i +: 8] == b) begin
				hit = 1'b1;
			end
		end
		return hit;
	endfunction

	task automatic emit_token(input res_kind_t k, input logic [7:0] d);
		step_res[step_n].kind = k;
		step_res[step_n].data = (k == RES_END) ? 8'd0 : d;
		step_res[step_n].last = 1'b0;
		step_n++;
		if (k == RES_BYTE) begin
			token_open = 1'b1;
		end
	endtask

	task automatic tokenize_item(input logic eos, input logic [7:0] b);
		step_n = 0;
		if (eos) begin
			if (held_valid) begin
				emit_token(RES_BYTE, held_byte);
			end
			if (token_open) begin
				emit_token(RES_END, 8'd0);
			end
			escape_pending = 1'b0;
			open_quote     = 8'd0;
			token_open     = 1'b0;
			held_byte      = 8'd0;
			held_valid     = 1'b0;
		end else if (escape_pending) begin
			escape_pending = 1'b0;
			emit_token(RES_BYTE, b);
		end else if (held_valid) begin
			held_valid = 1'b0;
			if (b == open_quote || in_char_set(b, esc_set)) begin
				emit_token(RES_BYTE, b);
			end else begin
				emit_token(RES_BYTE, held_byte);
				emit_token(RES_BYTE, b);
			end
			held_byte = 8'd0;
		end else if (open_quote != 8'd0) begin
			if (b == open_quote) begin
				open_quote = 8'd0;
			end else if (in_char_set(b, esc_set)) begin
				held_byte  = b;
				held_valid = 1'b1;
			end else begin
				emit_token(RES_BYTE, b);
			end
		end else if (in_char_set(b, delim_set)) begin
			if (token_open) begin
				emit_token(RES_END, 8'd0);
				token_open = 1'b0;
			end
		end else if (in_char_set(b, esc_set)) begin
			escape_pending = 1'b1;
		end else if (in_char_set(b, quote_set)) begin
			token_open = 1'b1;
			open_quote = b;
		end else begin
			emit_token(RES_BYTE, b);
		end
		if (step_n > 0) begin
			step_res[step_n-1].last = 1'b1;
		end
		for (int i = 0; i < step_n; i++) begin
			expected_tokens.push_back(step_res[i]);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delim_set      = '0;
			quote_set      = '0;
			esc_set        = '0;
			escape_pending = 1'b0;
			open_quote     = 8'd0;
			token_open     = 1'b0;
			held_byte      = 8'd0;
			held_valid     = 1'b0;
			mismatch_count = 0;
			tokens_pending = 0;
			expected_tokens.delete();
		end else begin
			// output side first: a result never leaves in the cycle of its input transfer
			if (m_tvalid && m_tready) begin
				if (expected_tokens.size() == 0) begin
					$error("result with nothing expected: out_kind %0d out_byte 0x%02h last %0b",
						m_tuser[0], m_tdata, m_tlast);
					mismatch_count++;
				end else begin
					want = expected_tokens.pop_front();
					if (m_tuser[0] !== want.kind) begin
						$error("out_kind: expected %0d, got %0d", want.kind, m_tuser[0]);
						mismatch_count++;
					end
					if (m_tdata !== want.data) begin
						$error("out_byte: expected 0x%02h, got 0x%02h", want.data, m_tdata);
						mismatch_count++;
					end
					if (m_tlast !== want.last) begin
						$error("last_of_run: expected %0b, got %0b", want.last, m_tlast);
						mismatch_count++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				tokenize_item(s_tuser[0], s_tdata);
			end
			if (psel && penable && pwrite && pready) begin
				case (paddr[ADDR_W-1:3])
					REG_DELIM:  delim_set = pwdata;
					REG_QUOTE:  quote_set = pwdata;
					REG_ESCAPE: esc_set   = pwdata;
					default: ;
				endcase
			end
			tokens_pending = expected_tokens.size();
		end
	end

endmodule

// ===== sim/tb_quoted_escaped_tokenizer.sv =====
`timescale 1ns / 1ps

module tb_quoted_escaped_tokenizer;
	import qet_pkg::*;

	localparam logic ITEM_BYTE = 1'b0;
	localparam logic ITEM_EOS  = 1'b1;
	localparam logic [ADDR_W-1:0] UNUSED_REG_ADDR = 5'h18;
	localparam int SETTLE_CYCLES = 20;
	localparam int PHASE_ITEMS   = 120;

	typedef enum int {
		SET_TYPICAL,
		SET_EMPTY,
		SET_ALL_FF,
		SET_SPARSE,
		SET_DENSE
	} setting_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [7:0]        s_tdata = 8'd0;
	logic [0:0]        s_tuser = ITEM_BYTE;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [7:0]        m_tdata;   // [7:0] out_byte
	logic [0:0]        m_tuser;   // [0] out_kind
	logic              m_tlast;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [CFG_W-1:0]  pwdata = '0;
	logic [CFG_W-1:0]  prdata;
	logic              pready;

	int mismatch_count;
	int tokens_pending;
	int items_sent = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	logic [CFG_W-1:0] cur_delim = '0;
	logic [CFG_W-1:0] cur_quote = '0;
	logic [CFG_W-1:0] cur_escape = '0;

	setting_t setting_plan [6] = '{SET_SPARSE, SET_EMPTY, SET_ALL_FF, SET_DENSE,
		SET_TYPICAL, SET_SPARSE};

	// {kind, in_byte}
	logic [8:0] directed_items [25] = '{
		{ITEM_BYTE, "a"}, {ITEM_BYTE, ","}, {ITEM_BYTE, " "}, {ITEM_BYTE, ","},
		{ITEM_BYTE, "\""}, {ITEM_BYTE, "\""}, {ITEM_BYTE, "\\"}, {ITEM_BYTE, ","},
		{ITEM_BYTE, "\""}, {ITEM_BYTE, "x"}, {ITEM_BYTE, "\\"}, {ITEM_BYTE, "\""},
		{ITEM_BYTE, "\\"}, {ITEM_BYTE, "\\"}, {ITEM_BYTE, "\\"}, {ITEM_BYTE, "y"},
		{ITEM_BYTE, "'"}, {ITEM_BYTE, 8'h00}, {ITEM_BYTE, 8'hFF}, {ITEM_BYTE, "\\"},
		{ITEM_EOS, 8'hA5}, {ITEM_BYTE, "\\"}, {ITEM_EOS, 8'h00}, {ITEM_BYTE, "\""},
		{ITEM_EOS, 8'hFF}
	};

	quoted_escaped_tokenizer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),   // [7:0] in_byte
		.s_tuser  (s_tuser),   // [0] kind
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),   // [7:0] out_byte
		.m_tuser  (m_tuser),   // [0] out_kind
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	qet_token_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.s_tuser        (s_tuser),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tuser        (m_tuser),
		.m_tlast        (m_tlast),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.pready         (pready),
		.mismatch_count (mismatch_count),
		.tokens_pending (tokens_pending)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	function automatic logic [7:0] set_member(input logic [CFG_W-1:0] chars);
		logic [7:0] found [8];
		int n;
		n = 0;
		for (int i = 0; i < SET_CHARS; i++) begin
			if (chars[8*i +: 8] != 8'd0) begin
				found[n] = chars[8*i +: 8];
				n++;
			end
		end
		if (n == 0) begin
			return 8'($urandom_range(8'h61, 8'h7A));
		end
		return found[$urandom_range(0, n - 1)];
	endfunction

	function automatic logic [7:0] plain_byte();
		if ($urandom_range(0, 5) == 0) begin
			return 8'($urandom_range(0, 255));
		end
		return 8'($urandom_range(8'h61, 8'h7A));
	endfunction

	function automatic logic [7:0] noise_byte();
		case ($urandom_range(0, 4))
			0: return set_member(cur_delim);
			1: return set_member(cur_quote);
			2: return set_member(cur_escape);
			3: return 8'($urandom_range(8'h61, 8'h7A));
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [CFG_W-1:0] sparse_set();
		logic [CFG_W-1:0] chars;
		chars = '0;
		for (int i = 0; i < SET_CHARS; i++) begin
			case ($urandom_range(0, 3))
				0, 1: chars[8*i +: 8] = 8'd0;
				2: chars[8*i +: 8] = 8'($urandom_range(8'h61, 8'h68));
				default: chars[8*i +: 8] = 8'($urandom_range(8'h20, 8'h2F));
			endcase
		end
		return chars;
	endfunction

	task automatic send_item(input logic kind, input logic [7:0] b);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tuser  <= kind;
		do @(posedge clk); while (!s_tready);
		items_sent++;
	endtask

	// drains every outstanding result, then lets the pipeline empty
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (tokens_pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [CFG_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
	endtask

	task automatic apply_setting(input logic [CFG_W-1:0] d, input logic [CFG_W-1:0] q,
		input logic [CFG_W-1:0] e);
		write_reg({REG_DELIM, 3'b000}, d);
		write_reg({REG_QUOTE, 3'b000}, q);
		write_reg({REG_ESCAPE, 3'b000}, e);
		psel       <= 1'b0;
		penable    <= 1'b0;
		pwrite     <= 1'b0;
		cur_delim  = d;
		cur_quote  = q;
		cur_escape = e;
	endtask

	task automatic apply_plan(input setting_t sel);
		case (sel)
			SET_TYPICAL: apply_setting(64'h0000_0000_093B_202C, 64'h0000_0000_0000_2722,
				64'h0000_0000_0000_5E5C);
			SET_EMPTY:   apply_setting('0, '0, '0);
			SET_ALL_FF:  apply_setting('1, '1, '1);
			SET_SPARSE:  apply_setting(sparse_set(), sparse_set(), sparse_set());
			default:     apply_setting({$urandom, $urandom}, {$urandom, $urandom},
				{$urandom, $urandom});
		endcase
	endtask

	// a string of delimited, quoted and escaped tokens closed by end of string
	task automatic send_phrase();
		logic [7:0] q;
		repeat ($urandom_range(1, 4)) begin
			repeat ($urandom_range(0, 2)) send_item(ITEM_BYTE, set_member(cur_delim));
			case ($urandom_range(0, 3))
				0, 1: repeat ($urandom_range(1, 5)) send_item(ITEM_BYTE, plain_byte());
				2: begin
					q = set_member(cur_quote);
					send_item(ITEM_BYTE, q);
					repeat ($urandom_range(0, 4)) begin
						if ($urandom_range(0, 2) == 0) begin
							send_item(ITEM_BYTE, set_member(cur_escape));
							case ($urandom_range(0, 2))
								0: send_item(ITEM_BYTE, q);
								1: send_item(ITEM_BYTE, set_member(cur_escape));
								default: send_item(ITEM_BYTE, plain_byte());
							endcase
						end else begin
							send_item(ITEM_BYTE, plain_byte());
						end
					end
					if ($urandom_range(0, 7) != 0) begin
						send_item(ITEM_BYTE, q);
					end
				end
				default: begin
					send_item(ITEM_BYTE, set_member(cur_escape));
					send_item(ITEM_BYTE, noise_byte());
				end
			endcase
		end
		if ($urandom_range(0, 4) == 0) begin
			send_item(ITEM_BYTE, set_member(cur_escape));
		end
		send_item(ITEM_EOS, 8'($urandom_range(0, 255)));
	endtask

	task automatic send_noise();
		repeat ($urandom_range(3, 15)) send_item(ITEM_BYTE, noise_byte());
		if ($urandom_range(0, 1) == 0) begin
			send_item(ITEM_EOS, 8'($urandom_range(0, 255)));
		end
	endtask

	initial begin
		int stop_at;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_reg(UNUSED_REG_ADDR, {$urandom, $urandom});
		apply_plan(SET_TYPICAL);
		@(posedge clk);
		for (int i = 0; i < 25; i++) begin
			send_item(directed_items[i][8], directed_items[i][7:0]);
		end

		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 28 : (ph == 1) ? 71 : 0;
			recv_idle_pct = (ph == 0) ? 71 : (ph == 1) ? 28 : 0;
			for (int k = 0; k < 2; k++) begin
				settle();
				apply_plan(setting_plan[2*ph+k]);
				@(posedge clk);
				stop_at = items_sent + PHASE_ITEMS;
				while (items_sent < stop_at) begin
					if ($urandom_range(0, 3) != 0) begin
						send_phrase();
					end else begin
						send_noise();
					end
					if ($urandom_range(0, 19) == 0) begin
						settle();
					end
				end
			end
		end

		settle();
		if (mismatch_count == 0 && tokens_pending == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

// ===== quoted_escaped_tokenizer.f =====
rtl/qet_pkg.sv
rtl/qet_regs.sv
rtl/qet_front.sv
rtl/qet_fifo.sv
rtl/qet_back.sv
rtl/quoted_escaped_tokenizer.sv
rtl/qet_checker.sv
sim/qet_token_checker.sv
sim/tb_quoted_escaped_tokenizer.sv
